/* src/lms_adaptive_noise_canceller_defines.svh */
// ---------------------------------------------------------------------------
// LMS noise canceller assertion macros
// Concurrent assertion shorthands, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef LMS_ADAPTIVE_NOISE_CANCELLER_DEFINES_SVH
`define LMS_ADAPTIVE_NOISE_CANCELLER_DEFINES_SVH

// Condition implies property in the same cycle.
`define LANC_ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Condition implies property in the following cycle.
`define LANC_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

/* src/lanc_pkg.sv */
// ---------------------------------------------------------------------------
// LMS noise canceller package
// Field widths, register indexes and defaults shared by the block's files.
// ---------------------------------------------------------------------------
`default_nettype none

package lanc_pkg;

    localparam int TAPS_DEF  = 30;
    localparam int SAMPLE_W  = 16;
    localparam int SUM_W     = 17;
    localparam int WEIGHT_W  = 64;
    localparam int ERR_W     = 40;
    localparam int SHIFT_W   = 6;
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 1;
    localparam int MUL_A_W   = 41;
    localparam int PROD_W    = MUL_A_W + SAMPLE_W;

    localparam logic [CFG_IDX_W-1:0] REG_OUT_MODE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SHIFT = 1'd1;

    localparam logic [SHIFT_W-1:0] STEP_SHIFT_RESET = 6'd40;

    // Output selection
    localparam logic MODE_ERROR = 1'b0;

endpackage

`default_nettype wire

/* src/lanc_ram.sv */
// ---------------------------------------------------------------------------
// LMS noise canceller RAM
// Simple dual-port memory: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module lanc_ram #(
    parameter int WIDTH = lanc_pkg::WEIGHT_W,
    parameter int DEPTH = lanc_pkg::TAPS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* src/lms_adaptive_noise_canceller.sv */
// ---------------------------------------------------------------------------
// LMS adaptive noise canceller
// Adaptive FIR on the reference noise, subtracted from desired plus noise,
// weights updated by LMS with a power-of-two step; one shared multiplier.
// ---------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  input     in         in_valid/in_stall  desired_sample, noise_sample
//  output    out        out_valid/out_stall out_sample
//  config    in         cfg_we             cfg_index, cfg_data
//
//  Each item runs a filter pass over the taps (states FHI, FLO, FACC: two
//  products of one 41x16 multiplier) and an update pass over the taps
//  (product, shift, saturating add) through the single weight memory port,
//  before the next item is accepted.
//  Reset clears the delay line through valid bits and the weights through
//  one written flag, no sweep.
//  A held output stalls completion, and the input with it, until it is taken.
// ---------------------------------------------------------------------------
`default_nettype none

`include "lms_adaptive_noise_canceller_defines.svh"

module lms_adaptive_noise_canceller #(
    parameter int TAPS = lanc_pkg::TAPS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic signed [lanc_pkg::SAMPLE_W-1:0] desired_sample,
    input  wire logic signed [lanc_pkg::SAMPLE_W-1:0] noise_sample,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic signed [lanc_pkg::SAMPLE_W-1:0]      out_sample,
    input  wire logic                                 cfg_we,
    input  wire logic [lanc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [lanc_pkg::CFG_W-1:0]           cfg_data
);

    localparam int IDX_W  = $clog2(TAPS);
    localparam int ACC_W  = 48 + $clog2(TAPS);
    localparam int DIFF_W = ACC_W + 1;
    localparam int SW     = lanc_pkg::SAMPLE_W;
    localparam int WW     = lanc_pkg::WEIGHT_W;
    localparam int EW     = lanc_pkg::ERR_W;
    localparam int PW     = lanc_pkg::PROD_W;
    localparam int QW     = 96;

    localparam logic [IDX_W-1:0] LAST   = IDX_W'(TAPS - 1);
    localparam logic [IDX_W:0]   TAPS_X = (IDX_W + 1)'(TAPS);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_FRD  = 4'd1;
    localparam logic [3:0] S_FHI  = 4'd2;
    localparam logic [3:0] S_FLO  = 4'd3;
    localparam logic [3:0] S_FACC = 4'd4;
    localparam logic [3:0] S_ERR  = 4'd5;
    localparam logic [3:0] S_UMUL = 4'd6;
    localparam logic [3:0] S_USH  = 4'd7;
    localparam logic [3:0] S_UADD = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    // Control state
    logic [3:0]                        state_reg, state_next;
    logic [IDX_W-1:0]                  idx_reg, idx_next;
    logic [IDX_W-1:0]                  head_reg, head_next;
    logic                              w_init_reg, w_init_next;
    logic [TAPS-1:0]                   svalid_reg, svalid_next;
    logic                              wv_rd_reg, sv_rd_reg;
    logic                              out_valid_reg, out_valid_next;
    logic                              out_mode_reg;
    logic [lanc_pkg::SHIFT_W-1:0]      step_shift_reg;

    // Datapath
    logic signed [ACC_W-1:0]           acc_reg, acc_next;
    logic signed [lanc_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic signed [EW-1:0]              e_reg, e_next;
    logic signed [PW-1:0]              prod_reg;
    logic signed [WW-1:0]              w_reg, w_next;
    logic signed [SW-1:0]              x_reg, x_next;
    logic signed [WW-1:0]              delta_reg, delta_next;
    logic signed [SW-1:0]              out_sample_reg, out_sample_next;

    logic [IDX_W-1:0]                  rd_idx;
    logic [IDX_W-1:0]                  s_raddr;
    logic [WW-1:0]                     w_rdata;
    logic [SW-1:0]                     s_rdata;
    logic signed [WW-1:0]              w_cur;
    logic signed [SW-1:0]              x_cur;
    logic                              w_we;
    logic signed [WW-1:0]              w_wdata;
    logic                              s_we;

    logic signed [lanc_pkg::MUL_A_W-1:0] mul_a;
    logic signed [SW-1:0]                mul_b;
    logic signed [PW-1:0]                mul_p;

    logic signed [ACC_W-1:0]           hi_term, lo_term;
    logic signed [DIFF_W-1:0]          diff;
    logic signed [QW-1:0]              q_up, q_sh;
    logic signed [WW:0]                wsum;
    logic signed [EW-17:0]             e_int;
    logic signed [SW-1:0]              err_out, sum_out;
    logic                              in_acc, out_free;

    function automatic logic [IDX_W-1:0] phys_idx(
        input logic [IDX_W-1:0] head,
        input logic [IDX_W-1:0] idx
    );
        logic [IDX_W:0] t;
        t = {1'b0, head} + {1'b0, idx};
        if (t >= TAPS_X)
        begin
            t = t - TAPS_X;
        end
        return t[IDX_W-1:0];
    endfunction

    assign in_stall   = (state_reg != S_IDLE);
    assign in_acc     = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;

    // Read the next tap ahead while the current one finishes
    always_comb
    begin
        rd_idx = idx_reg;
        if ((state_reg == S_FACC || state_reg == S_UADD) && idx_reg != LAST)
        begin
            rd_idx = idx_reg + 1'b1;
        end
    end

    assign s_raddr = phys_idx(head_reg, rd_idx);
    assign w_cur   = wv_rd_reg ? $signed(w_rdata) : '0;
    assign x_cur   = sv_rd_reg ? $signed(s_rdata) : '0;

    lanc_ram #(
        .WIDTH (WW),
        .DEPTH (TAPS)
    ) u_weight_ram (
        .clk   (clk),
        .we    (w_we),
        .waddr (idx_reg),
        .wdata (w_wdata),
        .raddr (rd_idx),
        .rdata (w_rdata)
    );

    lanc_ram #(
        .WIDTH (SW),
        .DEPTH (TAPS)
    ) u_sample_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (head_reg),
        .wdata (noise_sample),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    // Shared multiplier operand selection
    always_comb
    begin
        case (state_reg)
            S_FHI:
            begin
                mul_a = {{(lanc_pkg::MUL_A_W - 32){w_cur[WW-1]}}, w_cur[WW-1:32]};
                mul_b = x_cur;
            end
            S_FLO:
            begin
                mul_a = $signed({{(lanc_pkg::MUL_A_W - 32){1'b0}}, w_reg[31:0]});
                mul_b = x_reg;
            end
            S_UMUL:
            begin
                mul_a = {e_reg[EW-1], e_reg};
                mul_b = x_cur;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign hi_term = ACC_W'($signed(prod_reg[47:0]));
    assign lo_term = ACC_W'($signed(prod_reg[PW-1:32]));

    assign diff = (DIFF_W'(sum_reg) <<< 16) - DIFF_W'(acc_reg);

    // Scale by 2^(32 - step_shift): left shifts are exact in 96 bits, right floor
    assign q_up = QW'($signed({prod_reg, 32'b0}));
    assign q_sh = q_up >>> step_shift_reg;

    assign wsum = {w_reg[WW-1], w_reg} + {delta_reg[WW-1], delta_reg};

    // Truncate the error toward zero, then clamp
    always_comb
    begin
        e_int = e_reg[EW-1:16];
        if (e_reg[EW-1] && (e_reg[15:0] != '0))
        begin
            e_int = e_int + 1'b1;
        end
        if (e_int > (EW-16)'(32767))
        begin
            err_out = 16'sh7fff;
        end
        else if (e_int < -(EW-16)'(32768))
        begin
            err_out = -16'sh8000;
        end
        else
        begin
            err_out = e_int[SW-1:0];
        end
        if (sum_reg[lanc_pkg::SUM_W-1] != sum_reg[SW-1])
        begin
            sum_out = sum_reg[lanc_pkg::SUM_W-1] ? -16'sh8000 : 16'sh7fff;
        end
        else
        begin
            sum_out = sum_reg[SW-1:0];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        head_next       = head_reg;
        w_init_next     = w_init_reg;
        svalid_next     = svalid_reg;
        out_valid_next  = out_valid_reg;
        acc_next        = acc_reg;
        sum_next        = sum_reg;
        e_next          = e_reg;
        w_next          = w_reg;
        x_next          = x_reg;
        delta_next      = delta_reg;
        out_sample_next = out_sample_reg;
        w_we            = 1'b0;
        w_wdata         = wsum[WW-1:0];
        s_we            = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (wsum[WW] != wsum[WW-1])
        begin
            w_wdata = wsum[WW] ? {1'b1, {(WW-1){1'b0}}} : {1'b0, {(WW-1){1'b1}}};
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    s_we                  = 1'b1;
                    svalid_next[head_reg] = 1'b1;
                    sum_next   = lanc_pkg::SUM_W'(desired_sample)
                               + lanc_pkg::SUM_W'(noise_sample);
                    acc_next   = '0;
                    idx_next   = '0;
                    state_next = S_FRD;
                end
            end
            S_FRD:
            begin
                state_next = S_FHI;
            end
            S_FHI:
            begin
                w_next     = w_cur;
                x_next     = x_cur;
                state_next = S_FLO;
            end
            S_FLO:
            begin
                acc_next   = acc_reg + hi_term;
                state_next = S_FACC;
            end
            S_FACC:
            begin
                acc_next = acc_reg + lo_term;
                if (idx_reg == LAST)
                begin
                    idx_next   = '0;
                    state_next = S_ERR;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_FHI;
                end
            end
            S_ERR:
            begin
                if (diff[DIFF_W-1:EW-1] != {(DIFF_W-EW+1){diff[DIFF_W-1]}})
                begin
                    e_next = diff[DIFF_W-1] ? {1'b1, {(EW-1){1'b0}}}
                                            : {1'b0, {(EW-1){1'b1}}};
                end
                else
                begin
                    e_next = diff[EW-1:0];
                end
                state_next = S_UMUL;
            end
            S_UMUL:
            begin
                w_next     = w_cur;
                state_next = S_USH;
            end
            S_USH:
            begin
                if (q_sh[QW-1:WW-1] != {(QW-WW+1){q_sh[QW-1]}})
                begin
                    delta_next = q_sh[QW-1] ? {1'b1, {(WW-1){1'b0}}}
                                            : {1'b0, {(WW-1){1'b1}}};
                end
                else
                begin
                    delta_next = q_sh[WW-1:0];
                end
                state_next = S_UADD;
            end
            S_UADD:
            begin
                w_we = 1'b1;
                if (idx_reg == LAST)
                begin
                    // Every weight has now been written once
                    w_init_next = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_UMUL;
                end
            end
            S_DONE:
            begin
                // Hold until the output register is free, then retire the beat
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_sample_next = (out_mode_reg == lanc_pkg::MODE_ERROR) ? err_out
                                                                             : sum_out;
                    head_next  = (head_reg == '0) ? LAST : head_reg - 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            head_reg       <= '0;
            w_init_reg     <= 1'b0;
            svalid_reg     <= '0;
            wv_rd_reg      <= 1'b0;
            sv_rd_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_mode_reg   <= lanc_pkg::MODE_ERROR;
            step_shift_reg <= lanc_pkg::STEP_SHIFT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            head_reg      <= head_next;
            w_init_reg    <= w_init_next;
            svalid_reg    <= svalid_next;
            wv_rd_reg     <= w_init_reg;
            sv_rd_reg     <= svalid_reg[s_raddr];
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    lanc_pkg::REG_OUT_MODE:   out_mode_reg   <= cfg_data[0];
                    lanc_pkg::REG_STEP_SHIFT: step_shift_reg <= cfg_data;
                    default:                  out_mode_reg   <= out_mode_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg        <= acc_next;
        sum_reg        <= sum_next;
        e_reg          <= e_next;
        prod_reg       <= mul_p;
        w_reg          <= w_next;
        x_reg          <= x_next;
        delta_reg      <= delta_next;
        out_sample_reg <= out_sample_next;
    end

    `LANC_ASSERT_NEXT(a_accept_starts, in_acc, state_reg == S_FRD && idx_reg == '0, "accepted beat did not start the filter pass")
    `LANC_ASSERT_NEXT(a_done_loads, state_reg == S_DONE && out_free, out_valid_reg && state_reg == S_IDLE, "finished item did not reach the output register")
    `LANC_ASSERT_IMPL(a_idx_range, state_reg != S_IDLE, idx_reg <= LAST, "tap index beyond the last tap")
    `LANC_ASSERT_IMPL(a_head_range, 1'b1, head_reg <= LAST, "delay line head beyond the last tap")

endmodule

`default_nettype wire
